@@ hw/rtl/c6502_pkg.sv @@
// Package: 6502 core decode types, phase codes and decode function.
package c6502_pkg;

	typedef enum logic [3:0] {
		M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IND, M_IZX, M_IZY, M_REL
	} mode_t;

	typedef enum logic [5:0] {
		O_ORA, O_AND, O_EOR, O_ADC, O_STA, O_LDA, O_CMP, O_SBC,
		O_ASL, O_ROL, O_LSR, O_ROR, O_STX, O_LDX, O_DEC, O_INC,
		O_BIT, O_STY, O_LDY, O_CPY, O_CPX, O_JMP, O_JSR, O_BRK, O_RTI, O_RTS,
		O_PHP, O_PLP, O_PHA, O_PLA, O_IMPL, O_BRANCH, O_NOP
	} op_t;

	typedef enum logic [4:0] {
		PH_NULL, PH_OPC, PH_OPER, PH_ABSHI, PH_PTRLO, PH_PTRHI, PH_DATA, PH_RMW,
		PH_WRITE, PH_PUSHHI, PH_PUSHLO, PH_BRKST, PH_VECLO, PH_VECHI, PH_RTIST,
		PH_PULLLO, PH_PULLHI, PH_PULLONE
	} phase_t;

	typedef struct packed {
		mode_t mode;
		op_t   op;
	} dec_t;

	localparam logic [15:0] START_RESET = 16'h0300;
	localparam logic [7:0]  SP_RESET    = 8'hFD;
	localparam logic [7:0]  P_RESET     = 8'h20;

	function automatic op_t group0(input logic [2:0] aaa);
		op_t r;
		case (aaa)
			3'd1: r = O_BIT;
			3'd4: r = O_STY;
			3'd5: r = O_LDY;
			3'd6: r = O_CPY;
			3'd7: r = O_CPX;
			default: r = O_NOP;
		endcase
		return r;
	endfunction

	function automatic dec_t decode(input logic [7:0] opc);
		logic [2:0] aaa;
		logic [2:0] bbb;
		logic [1:0] cc;
		dec_t d;
		aaa = opc[7:5];
		bbb = opc[4:2];
		cc = opc[1:0];
		d.mode = M_IMP;
		d.op = O_NOP;
		if (cc == 2'd1) begin
			if (opc != 8'h89) begin
				d.op = op_t'({3'b000, aaa});
				case (bbb)
					3'd0: d.mode = M_IZX;
					3'd1: d.mode = M_ZP;
					3'd2: d.mode = M_IMM;
					3'd3: d.mode = M_ABS;
					3'd4: d.mode = M_IZY;
					3'd5: d.mode = M_ZPX;
					3'd6: d.mode = M_ABY;
					default: d.mode = M_ABX;
				endcase
			end
		end else if (cc == 2'd2) begin
			case (bbb)
				3'd0: if (opc == 8'hA2) begin
					d.op = O_LDX; d.mode = M_IMM;
				end
				3'd1: begin
					d.op = op_t'(6'd8 + {3'b000, aaa}); d.mode = M_ZP;
				end
				3'd2: begin
					if (!aaa[2]) begin
						d.op = op_t'(6'd8 + {3'b000, aaa}); d.mode = M_ACC;
					end else if (opc != 8'hEA) d.op = O_IMPL;
				end
				3'd3: begin
					d.op = op_t'(6'd8 + {3'b000, aaa}); d.mode = M_ABS;
				end
				3'd5: begin
					d.op = op_t'(6'd8 + {3'b000, aaa});
					d.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
				end
				3'd6: if (opc == 8'h9A || opc == 8'hBA) d.op = O_IMPL;
				3'd7: if (opc != 8'h9E) begin
					d.op = op_t'(6'd8 + {3'b000, aaa});
					d.mode = (aaa == 3'd5) ? M_ABY : M_ABX;
				end
				default: ;
			endcase
		end else if (cc == 2'd0) begin
			case (bbb)
				3'd0: begin
					if (opc == 8'h00) d.op = O_BRK;
					else if (opc == 8'h20) begin
						d.op = O_JSR; d.mode = M_ABS;
					end else if (opc == 8'h40) d.op = O_RTI;
					else if (opc == 8'h60) d.op = O_RTS;
					else if (aaa >= 3'd5) begin
						d.op = group0(aaa); d.mode = M_IMM;
					end
				end
				3'd1: begin
					d.op = group0(aaa); d.mode = M_ZP;
				end
				3'd2: begin
					if (opc == 8'h08) d.op = O_PHP;
					else if (opc == 8'h28) d.op = O_PLP;
					else if (opc == 8'h48) d.op = O_PHA;
					else if (opc == 8'h68) d.op = O_PLA;
					else d.op = O_IMPL;
				end
				3'd3: begin
					if (aaa == 3'd2) begin
						d.op = O_JMP; d.mode = M_ABS;
					end else if (aaa == 3'd3) begin
						d.op = O_JMP; d.mode = M_IND;
					end else begin
						d.op = group0(aaa); d.mode = M_ABS;
					end
				end
				3'd4: begin
					d.op = O_BRANCH; d.mode = M_REL;
				end
				3'd5: if (aaa == 3'd4 || aaa == 3'd5) begin
					d.op = group0(aaa); d.mode = M_ZPX;
				end
				3'd6: d.op = O_IMPL;
				default: if (opc == 8'hBC) begin
					d.op = O_LDY; d.mode = M_ABX;
				end
			endcase
		end else if (opc == 8'hEB) begin
			d.op = O_SBC; d.mode = M_IMM;
		end
		return d;
	endfunction

endpackage

@@ hw/rtl/cpu_6502_instruction_core_unit.sv @@
// 6502 instruction core: one bus access issued for each read reply taken.
// The next access is captured in the output register when a reply is taken.
// Throughput: one reply per cycle if the output is free; registers and phase update then.
// The output register may hold a result while a new reply is taken if the far side is ready.
// Reset: state at reset values, start 0x0300, null phase; bus fields are not reset.
module cpu_6502_instruction_core_unit
	import c6502_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] bus_address,
	output logic [7:0]  bus_write_data,
	output logic        bus_is_write,
	output logic        opcode_fetch,
	output logic [15:0] pc_now,
	output logic [7:0]  acc_now,
	output logic [7:0]  x_now,
	output logic [7:0]  y_now,
	output logic [7:0]  sp_now,
	output logic [7:0]  status_now
);

	logic [15:0] start_q, pc_q, ea_q, ptr_q;
	logic [7:0]  a_q, x_q, y_q, sp_q, p_q, opc_q, lat_q;
	phase_t      ph_q;

	logic [15:0] pc_d, ea_d, ptr_d;
	logic [7:0]  a_d, x_d, y_d, sp_d, p_d, opc_d, lat_d;
	phase_t      ph_d;
	logic [15:0] ra;
	logic [7:0]  rd;
	logic        rw, rf;

	logic [7:0]  b;
	dec_t        dq, db, dc;
	logic [15:0] t;
	logic        take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign take      = in_valid && in_ready;
	assign b         = read_data;
	assign dq        = decode(opc_q);
	assign db        = decode(b);
	assign t         = {b, lat_q};

	always_comb begin
		logic [8:0]  s;
		logic [7:0]  v, r, m;
		logic        brset;
		logic [15:0] tt;
		pc_d = pc_q; ea_d = ea_q; ptr_d = ptr_q;
		a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
		opc_d = opc_q; lat_d = lat_q; ph_d = ph_q;
		ra = 16'h0000; rd = 8'h00; rw = 1'b0; rf = 1'b0;
		s = 9'd0; v = 8'h00; r = 8'h00; m = 8'h00; brset = 1'b0; tt = t;
		dc = dq;

		unique case (ph_q)
			PH_OPC: begin
				opc_d = b;
				p_d = p_q | 8'h20;
				dc = db;
			end
			default: ;
		endcase

		unique case (ph_q)
			PH_NULL: begin
				ra = start_q; rf = 1'b1; pc_d = start_q + 16'd1; ph_d = PH_OPC;
			end
			PH_OPC: begin
				unique case (db.op)
					O_BRK: begin
						ptr_d = pc_q + 16'd1;
						ra = {8'h01, sp_q}; rw = 1'b1; rd = ptr_d[15:8];
						sp_d = sp_q - 8'd1; pc_d = ptr_d; ph_d = PH_PUSHHI;
					end
					O_RTI, O_RTS, O_PLP, O_PLA: begin
						sp_d = sp_q + 8'd1; ra = {8'h01, sp_d};
						ph_d = (db.op == O_RTI) ? PH_RTIST :
						       (db.op == O_RTS) ? PH_PULLLO : PH_PULLONE;
					end
					O_PHP, O_PHA: begin
						ra = {8'h01, sp_q}; rw = 1'b1;
						rd = (db.op == O_PHP) ? (p_d | 8'h10) : a_q;
						sp_d = sp_q - 8'd1; ph_d = PH_WRITE;
					end
					O_NOP, O_IMPL: begin
						if (db.op == O_IMPL) begin
							case (b)
								8'h18: p_d[0] = 1'b0;
								8'h38: p_d[0] = 1'b1;
								8'h58: p_d[2] = 1'b0;
								8'h78: p_d[2] = 1'b1;
								8'hB8: p_d[6] = 1'b0;
								8'hD8: p_d[3] = 1'b0;
								8'hF8: p_d[3] = 1'b1;
								8'h88: begin y_d = y_q - 8'd1; v = y_d; brset = 1'b1; end
								8'hC8: begin y_d = y_q + 8'd1; v = y_d; brset = 1'b1; end
								8'hCA: begin x_d = x_q - 8'd1; v = x_d; brset = 1'b1; end
								8'hE8: begin x_d = x_q + 8'd1; v = x_d; brset = 1'b1; end
								8'hA8: begin y_d = a_q; v = a_q; brset = 1'b1; end
								8'hAA: begin x_d = a_q; v = a_q; brset = 1'b1; end
								8'h98: begin a_d = y_q; v = y_q; brset = 1'b1; end
								8'h8A: begin a_d = x_q; v = x_q; brset = 1'b1; end
								8'hBA: begin x_d = sp_q; v = sp_q; brset = 1'b1; end
								8'h9A: sp_d = x_q;
								default: ;
							endcase
							if (brset) begin
								p_d[1] = (v == 8'h00); p_d[7] = v[7];
							end
						end
						ra = pc_q; rf = 1'b1; pc_d = pc_q + 16'd1; ph_d = PH_OPC;
					end
					default: begin
						if (db.mode == M_ACC) begin
							v = a_q;
							case (db.op)
								O_ASL: begin r = {v[6:0], 1'b0}; p_d[0] = v[7]; end
								O_ROL: begin r = {v[6:0], p_q[0]}; p_d[0] = v[7]; end
								O_LSR: begin r = {1'b0, v[7:1]}; p_d[0] = v[0]; end
								O_ROR: begin r = {p_q[0], v[7:1]}; p_d[0] = v[0]; end
								default: r = v;
							endcase
							p_d[1] = (r == 8'h00); p_d[7] = r[7];
							a_d = r;
							ra = pc_q; rf = 1'b1; pc_d = pc_q + 16'd1; ph_d = PH_OPC;
						end else if (db.mode == M_IMM) begin
							ea_d = pc_q; pc_d = pc_q + 16'd1;
						end else begin
							ra = pc_q; pc_d = pc_q + 16'd1; ph_d = PH_OPER;
						end
					end
				endcase
			end
			PH_OPER: begin
				unique case (dq.mode)
					M_ZP: ea_d = {8'h00, b};
					M_ZPX: ea_d = {8'h00, b + x_q};
					M_ZPY: ea_d = {8'h00, b + y_q};
					M_IZX, M_IZY: begin
						ptr_d = {8'h00, (dq.mode == M_IZX) ? b + x_q : b};
						ra = ptr_d; ph_d = PH_PTRLO;
					end
					M_REL: begin
						case (opc_q[7:6])
							2'd0: m = 8'h80;
							2'd1: m = 8'h40;
							2'd2: m = 8'h01;
							default: m = 8'h02;
						endcase
						brset = (p_q & m) != 8'h00;
						tt = pc_q;
						if (brset == opc_q[5]) tt = pc_q + {{8{b[7]}}, b};
						ra = tt; rf = 1'b1; pc_d = tt + 16'd1; ph_d = PH_OPC;
					end
					default: begin
						lat_d = b; ra = pc_q; pc_d = pc_q + 16'd1; ph_d = PH_ABSHI;
					end
				endcase
			end
			PH_ABSHI: begin
				if (dq.mode == M_IND) begin
					ptr_d = t; ra = t; ph_d = PH_PTRLO;
				end else begin
					if (dq.mode == M_ABX) tt = t + {8'h00, x_q};
					else if (dq.mode == M_ABY) tt = t + {8'h00, y_q};
					ea_d = tt;
				end
			end
			PH_PTRLO: begin
				lat_d = b; ra = {ptr_q[15:8], ptr_q[7:0] + 8'd1}; ph_d = PH_PTRHI;
			end
			PH_PTRHI: begin
				if (dq.mode == M_IZY) tt = t + {8'h00, y_q};
				ea_d = tt;
				if (dq.mode == M_IND) begin
					ra = tt; rf = 1'b1; pc_d = tt + 16'd1; ph_d = PH_OPC;
				end
			end
			PH_DATA: begin
				v = b;
				case (dq.op)
					O_ORA: begin a_d = a_q | v; p_d[1] = (a_d == 8'h00); p_d[7] = a_d[7]; end
					O_AND: begin a_d = a_q & v; p_d[1] = (a_d == 8'h00); p_d[7] = a_d[7]; end
					O_EOR: begin a_d = a_q ^ v; p_d[1] = (a_d == 8'h00); p_d[7] = a_d[7]; end
					O_ADC, O_SBC: begin
						m = (dq.op == O_SBC) ? ~v : v;
						s = {1'b0, a_q} + {1'b0, m} + {8'h00, p_q[0]};
						p_d[0] = s[8];
						p_d[6] = (s[7] ^ a_q[7]) & (s[7] ^ m[7]);
						a_d = s[7:0];
						p_d[1] = (a_d == 8'h00); p_d[7] = a_d[7];
					end
					O_LDA: begin a_d = v; p_d[1] = (v == 8'h00); p_d[7] = v[7]; end
					O_LDX: begin x_d = v; p_d[1] = (v == 8'h00); p_d[7] = v[7]; end
					O_LDY: begin y_d = v; p_d[1] = (v == 8'h00); p_d[7] = v[7]; end
					O_CMP, O_CPX, O_CPY: begin
						r = (dq.op == O_CMP) ? a_q : (dq.op == O_CPX) ? x_q : y_q;
						s = {1'b0, r} - {1'b0, v};
						p_d[0] = (r >= v); p_d[1] = (r == v); p_d[7] = s[7];
					end
					O_BIT: begin
						p_d[1] = ((a_q & v) == 8'h00);
						p_d[7] = v[7]; p_d[6] = v[6];
					end
					default: ;
				endcase
				ra = pc_q; rf = 1'b1; pc_d = pc_q + 16'd1; ph_d = PH_OPC;
			end
			PH_RMW: begin
				v = b;
				case (dq.op)
					O_ASL: begin r = {v[6:0], 1'b0}; p_d[0] = v[7]; end
					O_ROL: begin r = {v[6:0], p_q[0]}; p_d[0] = v[7]; end
					O_LSR: begin r = {1'b0, v[7:1]}; p_d[0] = v[0]; end
					O_ROR: begin r = {p_q[0], v[7:1]}; p_d[0] = v[0]; end
					O_DEC: r = v - 8'd1;
					O_INC: r = v + 8'd1;
					default: r = v;
				endcase
				p_d[1] = (r == 8'h00); p_d[7] = r[7];
				ra = ea_q; rd = r; rw = 1'b1; ph_d = PH_WRITE;
			end
			PH_PUSHHI: begin
				ra = {8'h01, sp_q}; rw = 1'b1; rd = ptr_q[7:0];
				sp_d = sp_q - 8'd1; ph_d = PH_PUSHLO;
			end
			PH_PUSHLO: begin
				if (dq.op == O_JSR) begin
					ra = ea_q; rf = 1'b1; pc_d = ea_q + 16'd1; ph_d = PH_OPC;
				end else begin
					ra = {8'h01, sp_q}; rw = 1'b1; rd = p_q | 8'h10;
					sp_d = sp_q - 8'd1; p_d = p_q | 8'h04; ph_d = PH_BRKST;
				end
			end
			PH_BRKST: begin
				ra = 16'hFFFE; ph_d = PH_VECLO;
			end
			PH_VECLO: begin
				lat_d = b; ra = 16'hFFFF; ph_d = PH_VECHI;
			end
			PH_VECHI: begin
				ra = t; rf = 1'b1; pc_d = t + 16'd1; ph_d = PH_OPC;
			end
			PH_RTIST: begin
				p_d = b | 8'h20; sp_d = sp_q + 8'd1; ra = {8'h01, sp_d}; ph_d = PH_PULLLO;
			end
			PH_PULLLO: begin
				lat_d = b; sp_d = sp_q + 8'd1; ra = {8'h01, sp_d}; ph_d = PH_PULLHI;
			end
			PH_PULLHI: begin
				tt = (dq.op == O_RTS) ? t + 16'd1 : t;
				ra = tt; rf = 1'b1; pc_d = tt + 16'd1; ph_d = PH_OPC;
			end
			PH_PULLONE: begin
				if (dq.op == O_PLA) begin
					a_d = b; p_d[1] = (b == 8'h00); p_d[7] = b[7];
				end else p_d = b | 8'h20;
				ra = pc_q; rf = 1'b1; pc_d = pc_q + 16'd1; ph_d = PH_OPC;
			end
			default: begin
				ra = pc_q; rf = 1'b1; pc_d = pc_q + 16'd1; ph_d = PH_OPC;
			end
		endcase

		// shared dispatch after the effective address is known
		if ((ph_q == PH_OPC && db.op != O_BRK && db.op != O_RTI && db.op != O_RTS &&
		     db.op != O_PHP && db.op != O_PHA && db.op != O_PLP && db.op != O_PLA &&
		     db.op != O_NOP && db.op != O_IMPL && db.mode == M_IMM) ||
		    (ph_q == PH_OPER && (dq.mode == M_ZP || dq.mode == M_ZPX || dq.mode == M_ZPY)) ||
		    (ph_q == PH_ABSHI && dq.mode != M_IND) ||
		    (ph_q == PH_PTRHI && dq.mode != M_IND)) begin
			unique case (dc.op)
				O_STA, O_STX, O_STY: begin
					ra = ea_d; rw = 1'b1; ph_d = PH_WRITE;
					rd = (dc.op == O_STA) ? a_q : (dc.op == O_STX) ? x_q : y_q;
				end
				O_ASL, O_ROL, O_LSR, O_ROR, O_DEC, O_INC: begin
					ra = ea_d; ph_d = PH_RMW;
				end
				O_JMP: begin
					ra = ea_d; rf = 1'b1; pc_d = ea_d + 16'd1; ph_d = PH_OPC;
				end
				O_JSR: begin
					ptr_d = pc_q - 16'd1;
					ra = {8'h01, sp_q}; rw = 1'b1; rd = ptr_d[15:8];
					sp_d = sp_q - 8'd1; ph_d = PH_PUSHHI;
				end
				default: begin
					ra = ea_d; ph_d = PH_DATA;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			pc_q <= START_RESET;
			a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00;
			sp_q <= SP_RESET; p_q <= P_RESET;
			opc_q <= 8'h00; lat_q <= 8'h00;
			ea_q <= 16'h0000; ptr_q <= 16'h0000;
			ph_q <= PH_NULL;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) start_q <= cfg_data;
			if (take) begin
				pc_q <= pc_d; a_q <= a_d; x_q <= x_d; y_q <= y_d;
				sp_q <= sp_d; p_q <= p_d; opc_q <= opc_d; lat_q <= lat_d;
				ea_q <= ea_d; ptr_q <= ptr_d; ph_q <= ph_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bus_address <= ra;
			bus_write_data <= rw ? rd : 8'h00;
			bus_is_write <= rw;
			opcode_fetch <= rf;
			pc_now <= pc_d;
			acc_now <= a_d;
			x_now <= x_d;
			y_now <= y_d;
			sp_now <= sp_d;
			status_now <= p_d;
		end
	end

endmodule

@@ dv/tb_cpu_6502_instruction_core_unit.sv @@
// Testbench for the 6502 instruction core: drives read replies, predicts and checks bus accesses.
module tb_cpu_6502_instruction_core_unit;
	import c6502_pkg::*;

	typedef struct {
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic        wr;
		logic        fetch;
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
	} access_t;

	class cpu_access_scoreboard;
		logic [15:0] start_addr, pc, ea, ptr;
		logic [7:0]  a, x, y, sp, p, opc, lat;
		phase_t      ph;
		access_t     req;
		access_t     pending_accesses[$];
		int          errors;

		function new();
			start_addr = START_RESET;
			pc = START_RESET;
			a = 0; x = 0; y = 0; sp = SP_RESET; p = P_RESET;
			opc = 0; lat = 0; ea = 0; ptr = 0;
			ph = PH_NULL;
			errors = 0;
		endfunction

		function bit next_is_fetch();
			return ph == PH_OPC;
		endfunction

		function op_t grp0(logic [2:0] aaa);
			case (aaa)
				3'd1: return O_BIT;
				3'd4: return O_STY;
				3'd5: return O_LDY;
				3'd6: return O_CPY;
				3'd7: return O_CPX;
				default: return O_NOP;
			endcase
		endfunction

		function void dec(logic [7:0] o, output mode_t m, output op_t k);
			logic [2:0] aaa, bbb;
			op_t sh;
			aaa = o[7:5];
			bbb = o[4:2];
			sh = op_t'(6'd8 + {3'b000, aaa});
			m = M_IMP;
			k = O_NOP;
			case (o[1:0])
				2'd1: if (o != 8'h89) begin
					k = op_t'({3'b000, aaa});
					case (bbb)
						3'd0: m = M_IZX;
						3'd1: m = M_ZP;
						3'd2: m = M_IMM;
						3'd3: m = M_ABS;
						3'd4: m = M_IZY;
						3'd5: m = M_ZPX;
						3'd6: m = M_ABY;
						default: m = M_ABX;
					endcase
				end
				2'd2: case (bbb)
					3'd0: if (o == 8'hA2) begin k = sh; m = M_IMM; end
					3'd1: begin k = sh; m = M_ZP; end
					3'd2: if (aaa < 4) begin
						k = sh; m = M_ACC;
					end else if (o != 8'hEA) k = O_IMPL;
					3'd3: begin k = sh; m = M_ABS; end
					3'd5: begin k = sh; m = (aaa == 4 || aaa == 5) ? M_ZPY : M_ZPX; end
					3'd6: if (o == 8'h9A || o == 8'hBA) k = O_IMPL;
					3'd7: if (o != 8'h9E) begin k = sh; m = (aaa == 5) ? M_ABY : M_ABX; end
					default: ;
				endcase
				2'd0: case (bbb)
					3'd0: begin
						if (o == 8'h00) k = O_BRK;
						else if (o == 8'h20) begin k = O_JSR; m = M_ABS; end
						else if (o == 8'h40) k = O_RTI;
						else if (o == 8'h60) k = O_RTS;
						else if (aaa >= 5) begin k = grp0(aaa); m = M_IMM; end
					end
					3'd1: begin k = grp0(aaa); m = M_ZP; end
					3'd2: case (o)
						8'h08: k = O_PHP;
						8'h28: k = O_PLP;
						8'h48: k = O_PHA;
						8'h68: k = O_PLA;
						default: k = O_IMPL;
					endcase
					3'd3: begin
						if (aaa == 2) begin k = O_JMP; m = M_ABS; end
						else if (aaa == 3) begin k = O_JMP; m = M_IND; end
						else begin k = grp0(aaa); m = M_ABS; end
					end
					3'd4: begin k = O_BRANCH; m = M_REL; end
					3'd5: if (aaa == 4 || aaa == 5) begin k = grp0(aaa); m = M_ZPX; end
					3'd6: k = O_IMPL;
					default: if (o == 8'hBC) begin k = O_LDY; m = M_ABX; end
				endcase
				default: if (o == 8'hEB) begin k = O_SBC; m = M_IMM; end
			endcase
		endfunction

		function void issue(logic [15:0] ad, logic [7:0] d, bit w, phase_t nph);
			req.addr = ad;
			req.wdata = w ? d : 8'h00;
			req.wr = w;
			req.fetch = 0;
			ph = nph;
		endfunction

		function void fetch_opc();
			issue(pc, 0, 0, PH_OPC);
			req.fetch = 1;
			pc = pc + 1;
		endfunction

		function void push(logic [7:0] d, phase_t nph);
			issue({8'h01, sp}, d, 1, nph);
			sp = sp - 1;
		endfunction

		function void pull(phase_t nph);
			sp = sp + 1;
			issue({8'h01, sp}, 0, 0, nph);
		endfunction

		function void setf(logic [7:0] mask, bit on);
			p = on ? (p | mask) : (p & ~mask);
		endfunction

		function void setnz(logic [7:0] v);
			setf(8'h02, v == 0);
			setf(8'h80, v[7]);
		endfunction

		function void add(logic [7:0] v);
			logic [8:0] s;
			s = a + v + p[0];
			setf(8'h01, s[8]);
			setf(8'h40, ((s[7:0] ^ a) & (s[7:0] ^ v) & 8'h80) != 0);
			a = s[7:0];
			setnz(a);
		endfunction

		function void compare(logic [7:0] r, logic [7:0] v);
			logic [7:0] dif;
			dif = r - v;
			setf(8'h01, r >= v);
			setf(8'h02, r == v);
			setf(8'h80, dif[7]);
		endfunction

		function void alu(op_t k, logic [7:0] v);
			case (k)
				O_ORA: begin a = a | v; setnz(a); end
				O_AND: begin a = a & v; setnz(a); end
				O_EOR: begin a = a ^ v; setnz(a); end
				O_ADC: add(v);
				O_SBC: add(~v);
				O_LDA: begin a = v; setnz(v); end
				O_LDX: begin x = v; setnz(v); end
				O_LDY: begin y = v; setnz(v); end
				O_CMP: compare(a, v);
				O_CPX: compare(x, v);
				O_CPY: compare(y, v);
				O_BIT: begin
					setf(8'h02, (a & v) == 0);
					p = (p & 8'h3F) | (v & 8'hC0);
				end
				default: ;
			endcase
		endfunction

		function logic [7:0] modify(op_t k, logic [7:0] v);
			logic       cin;
			logic [8:0] r;
			cin = p[0];
			r = {1'b0, v};
			case (k)
				O_ASL: begin r = {v, 1'b0}; setf(8'h01, r[8]); end
				O_ROL: begin r = {v, cin}; setf(8'h01, r[8]); end
				O_LSR: begin r = {2'b00, v[7:1]}; setf(8'h01, v[0]); end
				O_ROR: begin r = {1'b0, cin, v[7:1]}; setf(8'h01, v[0]); end
				O_DEC: r = {1'b0, v - 8'd1};
				O_INC: r = {1'b0, v + 8'd1};
				default: ;
			endcase
			setnz(r[7:0]);
			return r[7:0];
		endfunction

		function void implied(logic [7:0] o);
			case (o)
				8'h18: setf(8'h01, 0);
				8'h38: setf(8'h01, 1);
				8'h58: setf(8'h04, 0);
				8'h78: setf(8'h04, 1);
				8'hB8: setf(8'h40, 0);
				8'hD8: setf(8'h08, 0);
				8'hF8: setf(8'h08, 1);
				8'h88: begin y = y - 1; setnz(y); end
				8'hC8: begin y = y + 1; setnz(y); end
				8'hCA: begin x = x - 1; setnz(x); end
				8'hE8: begin x = x + 1; setnz(x); end
				8'hA8: begin y = a; setnz(y); end
				8'hAA: begin x = a; setnz(x); end
				8'h98: begin a = y; setnz(a); end
				8'h8A: begin a = x; setnz(a); end
				8'hBA: begin x = sp; setnz(x); end
				8'h9A: sp = x;
				default: ;
			endcase
		endfunction

		function void dispatch(op_t k);
			if (k == O_STA || k == O_STX || k == O_STY)
				issue(ea, (k == O_STA) ? a : (k == O_STX) ? x : y, 1, PH_WRITE);
			else if ((k >= O_ASL && k <= O_ROR) || k == O_DEC || k == O_INC)
				issue(ea, 0, 0, PH_RMW);
			else if (k == O_JMP) begin
				pc = ea;
				fetch_opc();
			end else if (k == O_JSR) begin
				ptr = pc - 1;
				push(ptr[15:8], PH_PUSHHI);
			end else
				issue(ea, 0, 0, PH_DATA);
		endfunction

		function void start_insn(logic [7:0] b);
			mode_t m;
			op_t   k;
			opc = b;
			p = p | 8'h20;
			dec(b, m, k);
			case (k)
				O_NOP: begin fetch_opc(); return; end
				O_IMPL: begin implied(b); fetch_opc(); return; end
				O_BRK: begin
					pc = pc + 1;
					ptr = pc;
					push(ptr[15:8], PH_PUSHHI);
					return;
				end
				O_RTI: begin pull(PH_RTIST); return; end
				O_RTS: begin pull(PH_PULLLO); return; end
				O_PHP: begin push(p | 8'h10, PH_WRITE); return; end
				O_PHA: begin push(a, PH_WRITE); return; end
				O_PLP, O_PLA: begin pull(PH_PULLONE); return; end
				default: ;
			endcase
			if (m == M_ACC) begin
				a = modify(k, a);
				fetch_opc();
			end else if (m == M_IMM) begin
				ea = pc;
				pc = pc + 1;
				dispatch(k);
			end else begin
				issue(pc, 0, 0, PH_OPER);
				pc = pc + 1;
			end
		endfunction

		function void operand(logic [7:0] b, mode_t m, op_t k);
			logic [7:0] mask;
			case (m)
				M_ZP: begin ea = {8'h00, b}; dispatch(k); end
				M_ZPX: begin ea = {8'h00, b + x}; dispatch(k); end
				M_ZPY: begin ea = {8'h00, b + y}; dispatch(k); end
				M_IZX: begin ptr = {8'h00, b + x}; issue(ptr, 0, 0, PH_PTRLO); end
				M_IZY: begin ptr = {8'h00, b}; issue(ptr, 0, 0, PH_PTRLO); end
				M_REL: begin
					case (opc[7:6])
						2'd0: mask = 8'h80;
						2'd1: mask = 8'h40;
						2'd2: mask = 8'h01;
						default: mask = 8'h02;
					endcase
					if (((p & mask) != 0) == opc[5])
						pc = pc + {{8{b[7]}}, b};
					fetch_opc();
				end
				default: begin
					lat = b;
					issue(pc, 0, 0, PH_ABSHI);
					pc = pc + 1;
				end
			endcase
		endfunction

		function void note_reply(logic [7:0] b);
			mode_t       m;
			op_t         k;
			logic [15:0] t;
			dec(opc, m, k);
			t = {b, lat};
			case (ph)
				PH_NULL: begin pc = start_addr; fetch_opc(); end
				PH_OPC: start_insn(b);
				PH_OPER: operand(b, m, k);
				PH_ABSHI: begin
					if (m == M_IND) begin
						ptr = t;
						issue(ptr, 0, 0, PH_PTRLO);
					end else begin
						if (m == M_ABX) t = t + x;
						else if (m == M_ABY) t = t + y;
						ea = t;
						dispatch(k);
					end
				end
				PH_PTRLO: begin
					lat = b;
					issue({ptr[15:8], ptr[7:0] + 8'd1}, 0, 0, PH_PTRHI);
				end
				PH_PTRHI: begin
					if (m == M_IZY) t = t + y;
					ea = t;
					if (m == M_IND) begin pc = ea; fetch_opc(); end
					else dispatch(k);
				end
				PH_DATA: begin alu(k, b); fetch_opc(); end
				PH_RMW: issue(ea, modify(k, b), 1, PH_WRITE);
				PH_PUSHHI: push(ptr[7:0], PH_PUSHLO);
				PH_PUSHLO: begin
					if (k == O_JSR) begin pc = ea; fetch_opc(); end
					else begin push(p | 8'h10, PH_BRKST); p = p | 8'h04; end
				end
				PH_BRKST: issue(16'hFFFE, 0, 0, PH_VECLO);
				PH_VECLO: begin lat = b; issue(16'hFFFF, 0, 0, PH_VECHI); end
				PH_VECHI: begin pc = t; fetch_opc(); end
				PH_RTIST: begin p = b | 8'h20; pull(PH_PULLLO); end
				PH_PULLLO: begin lat = b; pull(PH_PULLHI); end
				PH_PULLHI: begin pc = (k == O_RTS) ? t + 1 : t; fetch_opc(); end
				PH_PULLONE: begin
					if (k == O_PLA) begin a = b; setnz(b); end
					else p = b | 8'h20;
					fetch_opc();
				end
				default: fetch_opc();
			endcase
			req.pc = pc; req.a = a; req.x = x; req.y = y; req.sp = sp; req.p = p;
			pending_accesses.push_back(req);
		endfunction

		function void cmp_field(string f, int unsigned e, int unsigned g);
			if (e != g) begin
				errors++;
				$display("%0t %s mismatch: expected %0h actual %0h", $time, f, e, g);
			end
		endfunction

		function void check_access(access_t got);
			access_t e;
			if (pending_accesses.size() == 0) begin
				errors++;
				$display("%0t unexpected access: actual addr %0h", $time, got.addr);
				return;
			end
			e = pending_accesses.pop_front();
			cmp_field("bus_address", e.addr, got.addr);
			cmp_field("bus_write_data", e.wdata, got.wdata);
			cmp_field("bus_is_write", e.wr, got.wr);
			cmp_field("opcode_fetch", e.fetch, got.fetch);
			cmp_field("pc_now", e.pc, got.pc);
			cmp_field("acc_now", e.a, got.a);
			cmp_field("x_now", e.x, got.x);
			cmp_field("y_now", e.y, got.y);
			cmp_field("sp_now", e.sp, got.sp);
			cmp_field("status_now", e.p, got.p);
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid, in_ready;
	logic [7:0]  read_data;
	logic        out_valid, out_ready;
	logic [15:0] bus_address, pc_now;
	logic [7:0]  bus_write_data, acc_now, x_now, y_now, sp_now, status_now;
	logic        bus_is_write, opcode_fetch;

	cpu_access_scoreboard sb = new();
	int dir_idx = 0;
	int burst_left = 1;
	logic [7:0] dir_opcodes[12] = '{8'hA9, 8'h69, 8'hEB, 8'hF8, 8'h6C, 8'h00, 8'h40,
		8'h20, 8'h60, 8'h89, 8'hEA, 8'h28};

	cpu_6502_instruction_core_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .read_data(read_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.bus_address(bus_address), .bus_write_data(bus_write_data),
		.bus_is_write(bus_is_write), .opcode_fetch(opcode_fetch),
		.pc_now(pc_now), .acc_now(acc_now), .x_now(x_now), .y_now(y_now),
		.sp_now(sp_now), .status_now(status_now)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		access_t got;
		if (arst_n && out_valid && out_ready) begin
			got.addr = bus_address; got.wdata = bus_write_data;
			got.wr = bus_is_write; got.fetch = opcode_fetch;
			got.pc = pc_now; got.a = acc_now; got.x = x_now; got.y = y_now;
			got.sp = sp_now; got.p = status_now;
			sb.check_access(got);
		end
	end

	// Receiver: stalls in random stretches, with one long hold-off to back up the core
	initial begin
		int n, kind, cyc;
		cyc = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 40);
			kind = $urandom_range(0, 2);
			repeat (n) begin
				@(posedge clk);
				cyc++;
				if (cyc >= 150 && cyc < 300)
					out_ready <= 1'b0;
				else if (kind == 0)
					out_ready <= 1'b1;
				else if (kind == 1)
					out_ready <= $urandom_range(0, 1);
				else
					out_ready <= ($urandom_range(0, 4) != 0);
			end
		end
	end

	function automatic logic [7:0] pick_byte(bit directed);
		if (sb.next_is_fetch()) begin
			if (directed && dir_idx < 12)
				return dir_opcodes[dir_idx++];
			return $urandom_range(0, 255);
		end
		if (directed)
			return 8'hFF;
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic write_start(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.start_addr = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_items(int n, bit directed);
		logic [7:0] b;
		repeat (n) begin
			b = pick_byte(directed);
			in_valid <= 1'b1;
			read_data <= b;
			do @(posedge clk); while (!in_ready);
			sb.note_reply(b);
			if (--burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_accesses.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'h0000;
		in_valid = 1'b0;
		read_data = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_start(16'hFFFF);
		send_items(25, 1'b1);
		send_items(255, 1'b0);
		drain();
		write_start(16'h0000);
		send_items(285, 1'b0);
		drain();
		write_start($urandom_range(0, 65535));
		send_items(285, 1'b0);
		drain();
		if (sb.errors == 0)
			$display("cpu_6502_instruction_core_unit test passed");
		else
			$display("cpu_6502_instruction_core_unit test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("cpu_6502_instruction_core_unit test failed");
		$finish;
	end

endmodule
